// ----- rtl/uvr_pkg.sv -----
// uvr_pkg: shared types, constants and tables for the utf-8 validating recoder
// holds the byte class function, the dfa transition table and the queue entry type
// no dependencies
`default_nettype none

package uvr_pkg;

	// dfa state codes
	localparam int unsigned NUM_STATES  = 9;
	localparam int unsigned NUM_CLASSES = 12;

	typedef logic [3:0] dfa_state_t;
	typedef logic [3:0] byte_class_t;

	localparam dfa_state_t ST_ACCEPT = 4'd0;
	localparam dfa_state_t ST_REJECT = 4'd1;

	// code point accumulator
	localparam int unsigned CP_W = 21;
	typedef logic [CP_W-1:0] code_point_t;

	// queue between front and back
	localparam int unsigned QDEPTH = 8;       // power of two
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = QPTR_W + 1;

	// encoded length limits and lead byte marks
	localparam code_point_t CP_LIM_1 = 21'h00080;
	localparam code_point_t CP_LIM_2 = 21'h00800;
	localparam code_point_t CP_LIM_3 = 21'h10000;
	localparam logic [7:0] LEAD_2 = 8'hC0;
	localparam logic [7:0] LEAD_3 = 8'hE0;
	localparam logic [7:0] LEAD_4 = 8'hF0;
	localparam logic [7:0] CONT_MARK = 8'h80;

	// byte count minus one
	typedef logic [1:0] len_t;
	localparam len_t LEN_1 = 2'd0;
	localparam len_t LEN_2 = 2'd1;
	localparam len_t LEN_3 = 2'd2;
	localparam len_t LEN_4 = 2'd3;

	// input beat
	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_fresh;
	} item_t;

	// output beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       is_error;
	} result_t;

	// one finished code point or one error, as handed from front to back
	typedef struct packed {
		logic        is_error;
		len_t        len;
		code_point_t code_point;
	} q_entry_t;

	// next state by [state][class]
	localparam dfa_state_t NEXT_STATE [0:NUM_STATES-1][0:NUM_CLASSES-1] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
		'{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
		'{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
		'{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
		'{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
		'{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
		'{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
		'{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
		'{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
	};

	// sort a raw byte into its dfa class
	function automatic byte_class_t byte_class(input logic [7:0] b);
		byte_class_t cls;
		if (b < 8'h80)       cls = 4'd0;
		else if (b < 8'h90)  cls = 4'd1;
		else if (b < 8'hA0)  cls = 4'd9;
		else if (b < 8'hC0)  cls = 4'd7;
		else if (b < 8'hC2)  cls = 4'd8;
		else if (b < 8'hE0)  cls = 4'd2;
		else if (b == 8'hE0) cls = 4'd10;
		else if (b == 8'hED) cls = 4'd4;
		else if (b < 8'hF0)  cls = 4'd3;
		else if (b == 8'hF0) cls = 4'd11;
		else if (b < 8'hF4)  cls = 4'd6;
		else if (b == 8'hF4) cls = 4'd5;
		else                 cls = 4'd8;
		return cls;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/uvr_front.sv -----
// uvr_front: takes raw bytes, runs the utf-8 dfa and the code point accumulator
// pushes one queue entry per completed code point or per reject
// depends on uvr_pkg
`default_nettype none

module uvr_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	input  wire uvr_pkg::item_t  item,
	input  wire logic            q_full,
	output logic                 q_push,
	output uvr_pkg::q_entry_t    q_entry
);
	import uvr_pkg::*;

	dfa_state_t  state_q;
	code_point_t accum_q;

	dfa_state_t  st_cur;
	dfa_state_t  st_eff;
	dfa_state_t  st_nxt;
	code_point_t acc_cur;
	code_point_t acc_nxt;
	byte_class_t cls;
	logic [7:0]  lead_mask;
	logic        take;

	// dfa step for the byte on the input
	always_comb begin
		st_cur    = item.start_fresh ? ST_ACCEPT : state_q;
		acc_cur   = item.start_fresh ? '0 : accum_q;
		st_eff    = (st_cur < 4'(NUM_STATES)) ? st_cur : ST_REJECT;
		cls       = byte_class(item.data_byte);
		lead_mask = 8'hFF >> cls;
		if (st_eff != ST_ACCEPT) begin
			acc_nxt = {acc_cur[CP_W-7:0], item.data_byte[5:0]};
		end else begin
			acc_nxt = {{(CP_W-8){1'b0}}, item.data_byte & lead_mask};
		end
		st_nxt = NEXT_STATE[st_eff][cls];
	end

	assign item_ready = !q_full;
	assign take       = item_valid && item_ready;
	assign q_push     = take && (st_nxt == ST_ACCEPT || st_nxt == ST_REJECT);

	// classify the result: error, or encoded length of the code point
	always_comb begin
		q_entry.is_error   = (st_nxt == ST_REJECT);
		q_entry.code_point = acc_nxt;
		// an error is always a single beat
		if (st_nxt == ST_REJECT)     q_entry.len = LEN_1;
		else if (acc_nxt < CP_LIM_1) q_entry.len = LEN_1;
		else if (acc_nxt < CP_LIM_2) q_entry.len = LEN_2;
		else if (acc_nxt < CP_LIM_3) q_entry.len = LEN_3;
		else                         q_entry.len = LEN_4;
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
			accum_q <= '0;
		end else if (take) begin
			state_q <= st_nxt;
			accum_q <= acc_nxt;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/uvr_queue.sv -----
// uvr_queue: small fifo of decoded entries between front and back
// depends on uvr_pkg
`default_nettype none

module uvr_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire uvr_pkg::q_entry_t  push_entry,
	output logic                    full,
	input  wire logic               pop,
	output logic                    empty,
	output uvr_pkg::q_entry_t       head
);
	import uvr_pkg::*;

	q_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue pushed while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue popped while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- rtl/uvr_back.sv -----
// uvr_back: expands queue entries into utf-8 byte beats behind an output register
// depends on uvr_pkg
`default_nettype none

module uvr_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire uvr_pkg::q_entry_t  q_head,
	output logic                    q_pop,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output uvr_pkg::result_t        result
);
	import uvr_pkg::*;

	len_t       idx_q;
	logic       valid_q;
	result_t    res_q;
	logic       load;
	logic       last_byte;
	len_t       remain;
	logic [5:0] chunk;
	logic [7:0] byte_nxt;

	assign load      = (!valid_q || result_ready) && !q_empty;
	assign last_byte = (idx_q == q_head.len);
	assign q_pop     = load && last_byte;
	assign remain    = q_head.len - idx_q;

	// pick the six payload bits for this position
	always_comb begin
		case (remain)
			2'd0:    chunk = q_head.code_point[5:0];
			2'd1:    chunk = q_head.code_point[11:6];
			2'd2:    chunk = q_head.code_point[17:12];
			default: chunk = {3'b000, q_head.code_point[20:18]};
		endcase
	end

	// lead byte by length, continuation bytes after it, a zero byte for an error
	always_comb begin
		if (q_head.is_error) begin
			byte_nxt = '0;
		end else if (idx_q != '0) begin
			byte_nxt = CONT_MARK | {2'b00, chunk};
		end else begin
			case (q_head.len)
				LEN_1:   byte_nxt = q_head.code_point[7:0];
				LEN_2:   byte_nxt = LEAD_2 | {3'b000, q_head.code_point[10:6]};
				LEN_3:   byte_nxt = LEAD_3 | {4'b0000, q_head.code_point[15:12]};
				default: byte_nxt = LEAD_4 | {5'b00000, q_head.code_point[20:18]};
			endcase
		end
	end

	// byte position within the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (load) begin
			idx_q <= last_byte ? '0 : idx_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || result_ready) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.out_byte    <= byte_nxt;
			res_q.last_of_run <= last_byte;
			res_q.is_error    <= q_head.is_error;
		end
	end

	assign result_valid = valid_q;
	assign result       = res_q;

	a_idx_in_entry: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> idx_q <= q_head.len) else $error("byte index past entry length");
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.is_error) |-> (res_q.last_of_run && res_q.out_byte == '0))
		else $error("error beat not a lone zero beat");

endmodule

`default_nettype wire

// ----- rtl/utf8_validating_recoder.sv -----
// utf8_validating_recoder: one raw byte in per beat, re-encoded utf-8 bytes out
// instantiates uvr_front, uvr_queue and uvr_back; depends on uvr_pkg
//
// The block takes one byte per clock while its eight-entry queue has room and
// validates it with the standard utf-8 dfa. Each completed code point comes out
// as its 1 to 4 utf-8 bytes, one beat per clock while result_ready is high, the
// last marked by last_of_run; a byte inside a sequence gives no beat; each byte
// that leaves the decoder rejected gives one beat with out_byte zero,
// last_of_run and is_error set. Reject persists until a beat arrives with
// start_fresh set. Results pass the queue, then the output register. Output
// speed is one byte per clock from the back end, so input stalls only when
// decoded entries pile up in the queue behind a stalled result side.
`default_nettype none

module utf8_validating_recoder (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire uvr_pkg::item_t    item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output uvr_pkg::result_t       result
);
	import uvr_pkg::*;

	logic     q_full;
	logic     q_push;
	logic     q_pop;
	logic     q_empty;
	q_entry_t q_entry;
	q_entry_t q_head;

	// decode and classify
	uvr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_entry)
	);

	// decoupling queue
	uvr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	// re-encode and emit
	uvr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

// ----- tb/tb_utf8_validating_recoder.sv -----
// tb_utf8_validating_recoder: self-checking bench for the utf-8 validating recoder
// drives raw bytes, predicts re-encoded beats with its own dfa copy, checks each output beat
// depends on uvr_pkg and utf8_validating_recoder
`timescale 1ns / 1ps

module tb_utf8_validating_recoder;
	import uvr_pkg::*;

	// byte groups as the dfa sees them
	typedef enum logic [3:0] {
		GRP_ASCII   = 4'd0,
		GRP_CONT_8X = 4'd1,
		GRP_LEAD2   = 4'd2,
		GRP_LEAD3   = 4'd3,
		GRP_ED      = 4'd4,
		GRP_F4      = 4'd5,
		GRP_LEAD4   = 4'd6,
		GRP_CONT_AB = 4'd7,
		GRP_BAD     = 4'd8,
		GRP_CONT_9X = 4'd9,
		GRP_E0      = 4'd10,
		GRP_F0      = 4'd11
	} byte_group_t;

	// next decoder state by [state][group]
	localparam dfa_state_t DFA_NEXT [0:8][0:11] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
		'{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
		'{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
		'{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
		'{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
		'{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
		'{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
		'{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
		'{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
	};

	localparam result_t REJECT_BEAT = '{8'h00, 1'b1, 1'b1};
	localparam result_t NO_BEAT     = '0;
	localparam int      HOLD_CYCLES = 60;

	// directed rows; want is typed in only where the outcome is obvious
	typedef struct packed {
		item_t   beat;
		logic    typed;
		result_t want;
	} dir_row_t;

	localparam int N_DIR = 25;
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{'{8'h00, 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b0}},  // lowest ascii
		'{'{8'h7F, 1'b0}, 1'b1, '{8'h7F, 1'b1, 1'b0}},  // highest ascii
		'{'{8'hC2, 1'b0}, 1'b0, NO_BEAT},               // lowest two-byte point
		'{'{8'h80, 1'b0}, 1'b0, NO_BEAT},
		'{'{8'hE0, 1'b0}, 1'b0, NO_BEAT},               // lowest three-byte point
		'{'{8'hA0, 1'b0}, 1'b0, NO_BEAT},
		'{'{8'h80, 1'b0}, 1'b0, NO_BEAT},
		'{'{8'hF4, 1'b0}, 1'b0, NO_BEAT},               // highest code point
		'{'{8'h8F, 1'b0}, 1'b0, NO_BEAT},
		'{'{8'hBF, 1'b0}, 1'b0, NO_BEAT},
		'{'{8'hBF, 1'b0}, 1'b0, NO_BEAT},
		'{'{8'hF0, 1'b0}, 1'b0, NO_BEAT},               // lowest four-byte point
		'{'{8'h90, 1'b0}, 1'b0, NO_BEAT},
		'{'{8'h80, 1'b0}, 1'b0, NO_BEAT},
		'{'{8'h80, 1'b0}, 1'b0, NO_BEAT},
		'{'{8'h80, 1'b0}, 1'b1, REJECT_BEAT},           // stray continuation
		'{'{8'hFF, 1'b0}, 1'b1, REJECT_BEAT},           // reject stays put
		'{'{8'h41, 1'b1}, 1'b1, '{8'h41, 1'b1, 1'b0}},  // fresh start clears reject
		'{'{8'hED, 1'b1}, 1'b0, NO_BEAT},
		'{'{8'hA0, 1'b0}, 1'b1, REJECT_BEAT},           // surrogate half
		'{'{8'hE2, 1'b1}, 1'b0, NO_BEAT},
		'{'{8'h82, 1'b0}, 1'b0, NO_BEAT},
		'{'{8'h24, 1'b1}, 1'b1, '{8'h24, 1'b1, 1'b0}},  // fresh start mid-sequence
		'{'{8'hDF, 1'b0}, 1'b0, NO_BEAT},               // highest two-byte point
		'{'{8'hBF, 1'b0}, 1'b0, NO_BEAT}
	};

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_ready;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// decoder copy and pending output beats
	dfa_state_t  dec_state = ST_ACCEPT;
	code_point_t dec_accum = '0;
	result_t     expected_beats [$];

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   beats_sent    = 0;
	int   mismatch_count = 0;
	logic stall_rx      = 1'b0;
	event hold_off_go;

	utf8_validating_recoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic byte_group_t group_of(input logic [7:0] b);
		if (!b[7])                  return GRP_ASCII;
		if (b[7:4] == 4'h8)         return GRP_CONT_8X;
		if (b[7:4] == 4'h9)         return GRP_CONT_9X;
		if (b[7:6] == 2'b10)        return GRP_CONT_AB;
		if (b == 8'hC0 || b == 8'hC1) return GRP_BAD;
		if (b[7:5] == 3'b110)       return GRP_LEAD2;
		if (b == 8'hE0)             return GRP_E0;
		if (b == 8'hED)             return GRP_ED;
		if (b[7:4] == 4'hE)         return GRP_LEAD3;
		if (b == 8'hF0)             return GRP_F0;
		if (b <= 8'hF3)             return GRP_LEAD4;
		if (b == 8'hF4)             return GRP_F4;
		return GRP_BAD;
	endfunction

	// utf-8 bytes of a code point, returns the byte count
	function automatic int utf8_encode(input code_point_t cp, output logic [7:0] seq [4]);
		if (cp < 21'h80) begin
			seq[0] = cp[7:0];
			return 1;
		end
		if (cp < 21'h800) begin
			seq[0] = 8'hC0 | cp[10:6];
			seq[1] = 8'h80 | cp[5:0];
			return 2;
		end
		if (cp < 21'h10000) begin
			seq[0] = 8'hE0 | cp[15:12];
			seq[1] = 8'h80 | cp[11:6];
			seq[2] = 8'h80 | cp[5:0];
			return 3;
		end
		seq[0] = 8'hF0 | cp[20:18];
		seq[1] = 8'h80 | cp[17:12];
		seq[2] = 8'h80 | cp[11:6];
		seq[3] = 8'h80 | cp[5:0];
		return 4;
	endfunction

	// advance the decoder copy by one byte, returns the beats it gives
	function automatic int recode_byte(input item_t b, output result_t outs [4]);
		byte_group_t grp;
		dfa_state_t  cur;
		logic [7:0]  seq [4];
		int          n;
		int          k;
		if (b.start_fresh) begin
			dec_state = ST_ACCEPT;
			dec_accum = '0;
		end
		cur = (dec_state < 9) ? dec_state : ST_REJECT;
		grp = group_of(b.data_byte);
		if (cur != ST_ACCEPT)
			dec_accum = {dec_accum[14:0], b.data_byte[5:0]};
		else
			dec_accum = code_point_t'((8'hFF >> grp) & b.data_byte);
		dec_state = DFA_NEXT[cur][grp];
		if (dec_state == ST_REJECT) begin
			outs[0] = REJECT_BEAT;
			return 1;
		end
		if (dec_state != ST_ACCEPT)
			return 0;
		n = utf8_encode(dec_accum, seq);
		for (k = 0; k < n; k++)
			outs[k] = '{seq[k], (k == n - 1), 1'b0};
		return n;
	endfunction

	// offer one beat, with random idling ahead of it, and record what it should give
	task automatic send_beat(input item_t b, input logic typed = 1'b0,
			input result_t want = '0);
		int      gap;
		int      n;
		int      k;
		result_t outs [4];
		gap = 0;
		while (gap < 12 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= b;
		do @(posedge clk); while (!item_ready);
		beats_sent++;
		n = recode_byte(b, outs);
		if (typed)
			expected_beats.push_back(want);
		else
			for (k = 0; k < n; k++)
				expected_beats.push_back(outs[k]);
	endtask

	function automatic code_point_t pick_code_point(input int len);
		code_point_t cp;
		case (len)
			1: cp = code_point_t'($urandom_range(21'h7F));
			2: cp = code_point_t'($urandom_range(21'h7FF, 21'h80));
			3: do cp = code_point_t'($urandom_range(21'hFFFF, 21'h800));
				while (cp >= 21'hD800 && cp <= 21'hDFFF);
			default: cp = code_point_t'($urandom_range(21'h10FFFF, 21'h10000));
		endcase
		return cp;
	endfunction

	// one random run: a well-formed point, a cut-off sequence or a stray byte
	// short runs are single ascii beats
	task automatic send_random_run(input logic short_only = 1'b0);
		int          r;
		int          n;
		int          keep;
		int          k;
		logic        fresh;
		logic [7:0]  seq [4];
		r = short_only ? 0 : $urandom_range(99);
		fresh = (dec_state == ST_REJECT) ? ($urandom_range(3) != 0) : ($urandom_range(7) == 0);
		if (r < 85) begin
			n = utf8_encode(pick_code_point(short_only ? 1 : (r < 70 ? $urandom_range(4, 1)
					: $urandom_range(4, 2))), seq);
			keep = (r < 70) ? n : $urandom_range(n - 1, 1);
			for (k = 0; k < keep; k++)
				send_beat('{seq[k], (k == 0) && fresh});
		end else
			send_beat('{8'($urandom_range(255)), 1'($urandom_range(1))});
	endtask

	task automatic run_phase(input int tx_idle, input int rx_idle, input int n_beats);
		int target;
		send_idle_pct = tx_idle;
		recv_idle_pct = rx_idle;
		target = beats_sent + n_beats;
		while (beats_sent < target)
			send_random_run();
	endtask

	task automatic report_field(input string fname, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s expected %h, got %h", $time, fname, want, got);
			mismatch_count++;
		end
	endtask

	// receiver: checks each output beat, then picks its ready for the next cycle
	always @(posedge clk) begin
		result_t want;
		if (!arst_n)
			result_ready <= 1'b0;
		else begin
			if (result_valid && result_ready) begin
				if (expected_beats.size() == 0) begin
					$display("%0t ns: unexpected beat, expected none, got %h/%b/%b", $time,
						result.out_byte, result.last_of_run, result.is_error);
					mismatch_count++;
				end else begin
					want = expected_beats.pop_front();
					report_field("out_byte", want.out_byte, result.out_byte);
					report_field("last_of_run", want.last_of_run, result.last_of_run);
					report_field("is_error", want.is_error, result.is_error);
				end
			end
			result_ready <= !stall_rx && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// long receiver hold-off, counted here
	initial forever begin
		@(hold_off_go);
		stall_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		stall_rx <= 1'b0;
	end

	// main sequence
	initial begin
		int i;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows under the first idling mix
		send_idle_pct = 37;
		recv_idle_pct = 49;
		for (i = 0; i < N_DIR; i++)
			send_beat(DIR_ROWS[i].beat, DIR_ROWS[i].typed, DIR_ROWS[i].want);

		run_phase(37, 49, 23);

		// receiver stalls while the sender keeps pushing, then sender waits for drain
		send_idle_pct = 0;
		-> hold_off_go;
		for (i = 0; i < 16; i++)
			send_random_run(1'b1);
		item_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		@(posedge clk);

		run_phase(49, 37, 23);
		run_phase(0, 0, 22);

		item_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("utf8_validating_recoder: match");
		else
			$display("utf8_validating_recoder: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("utf8_validating_recoder: mismatch");
		$finish;
	end

endmodule
